// File: design/command_priority_output_core_macros.svh
// Assertion macros for the command priority output core.
// Used by command_priority_output_core.sv; expects clk and arst_n in scope.
`ifndef COMMAND_PRIORITY_OUTPUT_CORE_MACROS_SVH
`define COMMAND_PRIORITY_OUTPUT_CORE_MACROS_SVH

// same-cycle implication
`define CPO_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cpo implication check failed");

// next-cycle implication
`define CPO_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cpo next-cycle check failed");

`endif

// File: design/cpo_pkg.sv
// Shared types and constants for the command priority output core.
// No dependencies; imported by cpo_decode, cpo_encode and the top level.
`default_nettype none

package cpo_pkg;

	localparam int OPC_W  = 3;
	localparam int PRIO_W = 8;
	localparam int OPND_W = 16;
	localparam int REL_W  = 16;
	localparam int WIN_W  = 5;
	localparam int ERR_W  = 2;

	localparam logic [PRIO_W-1:0] RESERVED_PRIORITY = 8'd6;

	typedef enum logic [OPC_W-1:0] {
		OP_COMMAND    = 3'd0,
		OP_RELINQUISH = 3'd1,
		OP_DEFAULT    = 3'd2,
		OP_OOS        = 3'd3,
		OP_RELIAB     = 3'd4,
		OP_CLR_CHANGE = 3'd5
	} op_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE   = 2'd0,
		ERR_RANGE  = 2'd1,
		ERR_DENIED = 2'd2
	} err_t;

	// decoded controls for one command
	typedef struct packed {
		logic accepted;
		err_t fail_code;
		logic slot_set;
		logic slot_clr;
		logic dflt_wr;
		logic sweep;
		logic oos_wr;
		logic rel_wr;
		logic cov_clr;
	} cpo_ctrl_t;

endpackage

`default_nettype wire

// File: design/command_priority_output_core.sv
// Command priority output core: input register, single-pass state update, result register.
// Depends on cpo_pkg, cpo_decode, cpo_encode and command_priority_output_core_macros.svh.
//
// One command is taken per clock; busy stays low so start may be held every cycle.
// A command accepted at one clock edge is applied to the object state on the next
// edge, where its result is also registered and done is raised for a single cycle.
// The rate is one item per cycle, set by the combinational decode /
// priority-encode / update path from the input register into the state and result
// registers. Results cannot be held off, so the receiver must take each item in
// the cycle done is high. live_reliability may be written only while no command
// is in flight. There is no clearing pass after reset.
`default_nettype none

module command_priority_output_core #(
	parameter int NUM_PRIORITIES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [cpo_pkg::OPC_W-1:0]  opcode,
	input  wire logic [cpo_pkg::PRIO_W-1:0] cmd_priority,
	input  wire logic [cpo_pkg::OPND_W-1:0] operand,
	input  wire logic                       live_reliability_we,
	input  wire logic [cpo_pkg::REL_W-1:0]  live_reliability,
	output logic                            done,
	output logic                            accepted,
	output logic [cpo_pkg::ERR_W-1:0]       fail_code,
	output logic                            eff_value,
	output logic [cpo_pkg::WIN_W-1:0]       winning_priority,
	output logic                            fault_flag,
	output logic                            oos_status,
	output logic                            cov_changed
);
	import cpo_pkg::*;

	`include "command_priority_output_core_macros.svh"

	// input register
	logic              vld_s1;
	logic [OPC_W-1:0]  opcode_s1;
	logic [PRIO_W-1:0] prio_s1;
	logic [OPND_W-1:0] operand_s1;

	// object state
	logic [REL_W-1:0]          live_rel_q;
	logic [NUM_PRIORITIES-1:0] slot_values_q;
	logic [NUM_PRIORITIES-1:0] slot_valid_q;
	logic                      dflt_q;
	logic                      live_q;
	logic                      shadow_q;
	logic                      oos_q;
	logic [REL_W-1:0]          shadow_rel_q;
	logic                      prior_q;
	logic                      cov_q;

	// result register
	logic             done_s2;
	logic             accepted_s2;
	logic [ERR_W-1:0] fail_code_s2;
	logic             present_s2;
	logic [WIN_W-1:0] win_s2;
	logic             fault_s2;
	logic             oos_s2;
	logic             cov_s2;

	cpo_ctrl_t                 ctrl;
	logic [NUM_PRIORITIES-1:0] slot_sel;
	logic [NUM_PRIORITIES-1:0] slot_valid_n;
	logic [NUM_PRIORITIES-1:0] slot_values_n;
	logic                      any_set;
	logic [WIN_W-1:0]          win;
	logic                      win_value;
	logic                      sweep_val;
	logic                      dflt_n;
	logic                      live_n;
	logic                      shadow_n;
	logic                      oos_n;
	logic [REL_W-1:0]          shadow_rel_n;
	logic                      prior_n;
	logic                      cov_n;
	logic                      fault_n;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1  <= opcode;
			prio_s1    <= cmd_priority;
			operand_s1 <= operand;
		end
	end

	cpo_decode #(
		.NUM_PRIORITIES(NUM_PRIORITIES)
	) u_decode (
		.vld          (vld_s1),
		.opcode       (opcode_s1),
		.cmd_priority (prio_s1),
		.operand      (operand_s1),
		.oos          (oos_q),
		.ctrl         (ctrl),
		.slot_sel     (slot_sel)
	);

	always_comb begin
		slot_valid_n  = slot_valid_q;
		slot_values_n = slot_values_q;
		if (ctrl.slot_set) begin
			slot_valid_n  = slot_valid_q | slot_sel;
			slot_values_n = (slot_values_q & ~slot_sel) |
				(slot_sel & {NUM_PRIORITIES{operand_s1[0]}});
		end
		if (ctrl.slot_clr) begin
			slot_valid_n = slot_valid_q & ~slot_sel;
		end
	end

	assign dflt_n = ctrl.dflt_wr ? operand_s1[0] : dflt_q;

	cpo_encode #(
		.NUM_PRIORITIES(NUM_PRIORITIES)
	) u_encode (
		.slot_valid  (slot_valid_n),
		.slot_values (slot_values_n),
		.any_set     (any_set),
		.win         (win),
		.win_value   (win_value)
	);

	assign sweep_val    = any_set ? win_value : dflt_n;
	assign oos_n        = ctrl.oos_wr ? (operand_s1 != '0) : oos_q;
	assign shadow_rel_n = ctrl.rel_wr ? operand_s1 : shadow_rel_q;

	always_comb begin
		live_n   = live_q;
		shadow_n = shadow_q;
		prior_n  = prior_q;
		cov_n    = cov_q;
		// sweeps only come from opcodes that leave out-of-service alone
		if (ctrl.sweep) begin
			if (sweep_val != prior_q) begin
				cov_n   = 1'b1;
				prior_n = sweep_val;
			end
			if (oos_q) begin
				shadow_n = sweep_val;
			end else begin
				live_n = sweep_val;
			end
		end
		if (ctrl.oos_wr && (oos_n != oos_q)) begin
			cov_n = 1'b1;
		end
		if (ctrl.cov_clr) begin
			cov_n = 1'b0;
		end
		// in-service catch-up of the reported value
		if (!oos_n && (live_n != prior_n)) begin
			cov_n   = 1'b1;
			prior_n = live_n;
		end
	end

	assign fault_n = oos_n ? (shadow_rel_n != '0) : (live_rel_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_rel_q    <= '0;
			slot_values_q <= '0;
			slot_valid_q  <= '0;
			dflt_q        <= 1'b0;
			live_q        <= 1'b0;
			shadow_q      <= 1'b0;
			oos_q         <= 1'b0;
			shadow_rel_q  <= '0;
			prior_q       <= 1'b0;
			cov_q         <= 1'b0;
		end else begin
			if (live_reliability_we) begin
				live_rel_q <= live_reliability;
			end
			if (vld_s1) begin
				slot_values_q <= slot_values_n;
				slot_valid_q  <= slot_valid_n;
				dflt_q        <= dflt_n;
				live_q        <= live_n;
				shadow_q      <= shadow_n;
				oos_q         <= oos_n;
				shadow_rel_q  <= shadow_rel_n;
				prior_q       <= prior_n;
				cov_q         <= cov_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			accepted_s2  <= ctrl.accepted;
			fail_code_s2 <= ctrl.fail_code;
			present_s2   <= oos_n ? shadow_n : live_n;
			win_s2       <= win;
			fault_s2     <= fault_n;
			oos_s2       <= oos_n;
			cov_s2       <= cov_n;
		end
	end

	assign done             = done_s2;
	assign accepted         = accepted_s2;
	assign fail_code        = fail_code_s2;
	assign eff_value        = present_s2;
	assign winning_priority = win_s2;
	assign fault_flag       = fault_s2;
	assign oos_status       = oos_s2;
	assign cov_changed      = cov_s2;

	`CPO_ASSERT_IMP(a_acc_no_err, done && accepted, fail_code == ERR_NONE)
	`CPO_ASSERT_NXT(a_no_spurious, !vld_s1, !done)
	`CPO_ASSERT_IMP(a_prior_tracks, done && !oos_status, prior_q == eff_value)

endmodule

`default_nettype wire

// File: design/cpo_decode.sv
// Command decode: validates priority and operand, produces the update controls.
// Depends on cpo_pkg.
`default_nettype none

module cpo_decode #(
	parameter int NUM_PRIORITIES = 16
) (
	input  wire logic                       vld,
	input  wire logic [cpo_pkg::OPC_W-1:0]  opcode,
	input  wire logic [cpo_pkg::PRIO_W-1:0] cmd_priority,
	input  wire logic [cpo_pkg::OPND_W-1:0] operand,
	input  wire logic                       oos,
	output cpo_pkg::cpo_ctrl_t              ctrl,
	output logic [NUM_PRIORITIES-1:0]       slot_sel
);
	import cpo_pkg::*;

	logic prio_ok;
	logic bit_ok;

	assign prio_ok = (cmd_priority != '0) &&
		(cmd_priority <= PRIO_W'(NUM_PRIORITIES)) &&
		(cmd_priority != RESERVED_PRIORITY);
	assign bit_ok = (operand[OPND_W-1:1] == '0);

	always_comb begin
		for (int i = 0; i < NUM_PRIORITIES; i++) begin
			slot_sel[i] = (cmd_priority == PRIO_W'(i + 1));
		end
	end

	always_comb begin
		op_t op;
		op = op_t'(opcode);
		ctrl = '0;
		ctrl.fail_code = ERR_NONE;
		if (vld) begin
			case (op)
				OP_COMMAND: begin
					if (prio_ok && bit_ok) begin
						ctrl.slot_set = 1'b1;
						ctrl.sweep    = 1'b1;
						ctrl.accepted = 1'b1;
					end else if (cmd_priority == RESERVED_PRIORITY) begin
						ctrl.fail_code = ERR_DENIED;
					end else begin
						ctrl.fail_code = ERR_RANGE;
					end
				end
				OP_RELINQUISH: begin
					if (prio_ok) begin
						ctrl.slot_clr = 1'b1;
						ctrl.sweep    = 1'b1;
						ctrl.accepted = 1'b1;
					end else begin
						ctrl.fail_code = ERR_RANGE;
					end
				end
				OP_DEFAULT: begin
					if (bit_ok) begin
						ctrl.dflt_wr  = 1'b1;
						ctrl.sweep    = 1'b1;
						ctrl.accepted = 1'b1;
					end else begin
						ctrl.fail_code = ERR_RANGE;
					end
				end
				OP_OOS: begin
					ctrl.oos_wr   = 1'b1;
					ctrl.accepted = 1'b1;
				end
				OP_RELIAB: begin
					// shadow reliability only writable while out of service
					if (oos) begin
						ctrl.rel_wr   = 1'b1;
						ctrl.accepted = 1'b1;
					end else begin
						ctrl.fail_code = ERR_DENIED;
					end
				end
				OP_CLR_CHANGE: begin
					ctrl.cov_clr  = 1'b1;
					ctrl.accepted = 1'b1;
				end
				default: begin
					ctrl = '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/cpo_encode.sv
// Priority encoder over the slot array: lowest numbered valid slot wins.
// Depends on cpo_pkg.
`default_nettype none

module cpo_encode #(
	parameter int NUM_PRIORITIES = 16
) (
	input  wire logic [NUM_PRIORITIES-1:0] slot_valid,
	input  wire logic [NUM_PRIORITIES-1:0] slot_values,
	output logic                           any_set,
	output logic [cpo_pkg::WIN_W-1:0]      win,
	output logic                           win_value
);
	import cpo_pkg::*;

	always_comb begin
		any_set   = 1'b0;
		win       = '0;
		win_value = 1'b0;
		// scan high to low so the lowest set slot is left standing
		for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
			if (slot_valid[i]) begin
				any_set   = 1'b1;
				win       = WIN_W'(i + 1);
				win_value = slot_values[i];
			end
		end
	end

endmodule

`default_nettype wire
